// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with reset disable, switchable by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== sv/cdsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date step package
// Shared types, packing constants and digit helpers.
// ----------------------------------------------------------------------------
package cdsp_pkg;

  localparam logic [23:0] DATE_MIN    = 24'd1010001;
  localparam logic [23:0] DATE_MAX    = 24'd12319999;
  localparam logic [23:0] DATE_WRAP   = 24'd1010000;
  localparam logic [23:0] MONTH_UNIT  = 24'd1000000;
  localparam logic [23:0] DAY_UNIT    = 24'd10000;
  localparam int          MONTH_MAX   = 12;

  // floor(x/10000) for x < 2^20: (x * 1717987) >> 34
  localparam logic [20:0] RECIP_10K   = 21'd1717987;
  localparam int          RECIP_10K_SH = 34;
  // floor(x/100) for x < 2^14: (x * 20972) >> 21
  localparam logic [14:0] RECIP_100   = 15'd20972;
  localparam int          RECIP_100_SH = 21;
  // floor(x/10) for x < 128: (x * 205) >> 11
  localparam logic [14:0] RECIP_10    = 15'd205;
  localparam int          RECIP_10_SH = 11;

  localparam logic [13:0] HUNDRED     = 14'd100;
  localparam logic [3:0]  TEN         = 4'd10;

  typedef struct packed {
    logic valid;
    logic err;
  } flow_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [6:0]  day;
    logic [13:0] year;
  } date_t;

  // decimal digits of day and year
  typedef struct packed {
    logic [6:0] yh;         // year / 100
    logic [6:0] yl;         // year % 100
    logic [3:0] day_tens;
    logic [3:0] yh_tens;
  } dig_t;

  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [14:0] prod;
    prod = {8'd0, x} * RECIP_10;
    return prod[RECIP_10_SH +: 4];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] x, input logic [3:0] tens);
    logic [6:0] t10;
    t10 = {3'd0, tens} * {3'd0, TEN};
    return 4'(x - t10);
  endfunction

endpackage

// ===== sv/calendar_date_step_palindrome_core.sv =====
// ----------------------------------------------------------------------------
// Calendar date step with palindrome test
// Throughput: one request per cycle while the result is not stalled; all eight stages advance together.
// A stalled result holds every stage; in_ready drops only while it waits.
// Reset clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_step_palindrome_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_date_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_next_date,
  output logic        out_is_palindrome,
  output logic        out_range_error,
  output logic        out_year_overflow
);
  import cdsp_pkg::*;

  logic  adv;
  flow_t flow_a, flow_b;
  date_t date_a, date_b;
  dig_t  dig_b;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  cdsp_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_date  (in_date_value),
    .flow_o   (flow_a),
    .date_o   (date_a)
  );

  cdsp_digits u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .flow_i (flow_a),
    .date_i (date_a),
    .flow_o (flow_b),
    .date_o (date_b),
    .dig_o  (dig_b)
  );

  cdsp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .flow_i    (flow_b),
    .date_i    (date_b),
    .dig_i     (dig_b),
    .out_valid (out_valid),
    .next_date (out_next_date),
    .is_pal    (out_is_palindrome),
    .range_err (out_range_error),
    .year_ovf  (out_year_overflow)
  );

  `ASSERT_IMPLY(a_err_clears, clk, rst_n, out_valid && out_range_error, out_next_date == 24'd0 && !out_is_palindrome && !out_year_overflow)
  `ASSERT_IMPLY(a_ovf_wrap, clk, rst_n, out_valid && out_year_overflow, out_next_date == DATE_WRAP)
  `ASSERT_IMPLY(a_next_span, clk, rst_n, out_valid && !out_range_error, out_next_date >= DATE_WRAP && out_next_date <= DATE_MAX)

endmodule

// ===== sv/cdsp_split.sv =====
// ----------------------------------------------------------------------------
// Date split
// Four stages: range check and month, month remainder, day, year.
// ----------------------------------------------------------------------------
module cdsp_split (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [23:0]     in_date,
  output cdsp_pkg::flow_t flow_o,
  output cdsp_pkg::date_t date_o
);
  import cdsp_pkg::*;

  flow_t       flow1_nxt, flow1_r, flow2_r, flow3_r, flow4_r;
  logic [23:0] v1_r;
  logic [3:0]  m1_nxt, m1_r, m2_r, m3_r;
  logic [19:0] rem2_nxt, rem2_r, rem3_r;
  logic [40:0] prod3;
  logic [6:0]  d3_nxt, d3_r;
  logic [23:0] dsub4;
  date_t       date4_nxt, date4_r;

  // month is the highest count of millions, up to MONTH_MAX, not above the value
  always_comb begin
    flow1_nxt.valid = in_valid;
    flow1_nxt.err   = (in_date < DATE_MIN) || (in_date > DATE_MAX);
    m1_nxt = '0;
    for (int k = 1; k <= MONTH_MAX; k++) begin
      if (in_date >= 24'(MONTH_UNIT * 24'(k))) m1_nxt = 4'(k);
    end
  end

  assign rem2_nxt = 20'(v1_r - MONTH_UNIT * {20'd0, m1_r});
  assign prod3    = {21'd0, rem2_r} * {20'd0, RECIP_10K};
  assign d3_nxt   = prod3[RECIP_10K_SH +: 7];
  assign dsub4    = {4'd0, rem3_r} - {17'd0, d3_r} * DAY_UNIT;

  always_comb begin
    date4_nxt.month = m3_r;
    date4_nxt.day   = d3_r;
    date4_nxt.year  = dsub4[13:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow1_r <= '0;
      flow2_r <= '0;
      flow3_r <= '0;
      flow4_r <= '0;
    end else if (adv) begin
      flow1_r <= flow1_nxt;
      flow2_r <= flow1_r;
      flow3_r <= flow2_r;
      flow4_r <= flow3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r    <= in_date;
      m1_r    <= m1_nxt;
      m2_r    <= m1_r;
      rem2_r  <= rem2_nxt;
      m3_r    <= m2_r;
      rem3_r  <= rem2_r;
      d3_r    <= d3_nxt;
      date4_r <= date4_nxt;
    end
  end

  assign flow_o = flow4_r;
  assign date_o = date4_r;

endmodule

// ===== sv/cdsp_digits.sv =====
// ----------------------------------------------------------------------------
// Digit extraction
// Two stages: year hundreds, then year low part and tens digits.
// ----------------------------------------------------------------------------
module cdsp_digits (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  cdsp_pkg::flow_t flow_i,
  input  cdsp_pkg::date_t date_i,
  output cdsp_pkg::flow_t flow_o,
  output cdsp_pkg::date_t date_o,
  output cdsp_pkg::dig_t  dig_o
);
  import cdsp_pkg::*;

  flow_t       flow5_r, flow6_r;
  date_t       date5_r, date6_r;
  logic [28:0] prod5;
  logic [6:0]  yh5_nxt, yh5_r;
  logic [13:0] ysub6;
  dig_t        dig6_nxt, dig6_r;

  assign prod5   = {15'd0, date_i.year} * {14'd0, RECIP_100};
  assign yh5_nxt = prod5[RECIP_100_SH +: 7];
  assign ysub6   = date5_r.year - 14'(yh5_r) * HUNDRED;

  always_comb begin
    dig6_nxt.yh       = yh5_r;
    dig6_nxt.yl       = ysub6[6:0];
    dig6_nxt.day_tens = tens_of(date5_r.day);
    dig6_nxt.yh_tens  = tens_of(yh5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow5_r <= '0;
      flow6_r <= '0;
    end else if (adv) begin
      flow5_r <= flow_i;
      flow6_r <= flow5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      date5_r <= date_i;
      yh5_r   <= yh5_nxt;
      date6_r <= date5_r;
      dig6_r  <= dig6_nxt;
    end
  end

  assign flow_o = flow6_r;
  assign date_o = date6_r;
  assign dig_o  = dig6_r;

endmodule

// ===== sv/cdsp_step.sv =====
// ----------------------------------------------------------------------------
// Day step and packing
// Palindrome test, leap year, next day, then repacking into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdsp_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  cdsp_pkg::flow_t flow_i,
  input  cdsp_pkg::date_t date_i,
  input  cdsp_pkg::dig_t  dig_i,
  output logic            out_valid,
  output logic [23:0]     next_date,
  output logic            is_pal,
  output logic            range_err,
  output logic            year_ovf
);
  import cdsp_pkg::*;

  typedef struct packed {
    date_t date;
    logic  pal;
    logic  ovf;
  } step_t;

  flow_t       flow7_r;
  step_t       step7_nxt, step7_r;
  logic        valid8_r;
  logic [23:0] next8_nxt, next8_r;
  logic        pal8_r, err8_r, ovf8_r;

  logic [3:0]  m_tens, m_ones, yl_tens, yl_ones, d_ones, yh_ones;
  logic        leap;
  logic [4:0]  dim;
  logic        year_end;

  always_comb begin
    m_tens  = (date_i.month >= TEN) ? 4'd1 : 4'd0;
    m_ones  = (date_i.month >= TEN) ? 4'(date_i.month - TEN) : date_i.month;
    yl_tens = tens_of(dig_i.yl);
    yl_ones = ones_of(dig_i.yl, yl_tens);
    d_ones  = ones_of(date_i.day, dig_i.day_tens);
    yh_ones = ones_of(dig_i.yh, dig_i.yh_tens);

    // century years are leap only when the hundreds count is a multiple of four
    leap = (dig_i.yl == 7'd0) ? (dig_i.yh[1:0] == 2'd0) : (date_i.year[1:0] == 2'd0);

    if (((date_i.month < 4'd8) && date_i.month[0]) ||
        ((date_i.month >= 4'd8) && !date_i.month[0])) begin
      dim = 5'd31;
    end else if (date_i.month == 4'd2) begin
      dim = leap ? 5'd29 : 5'd28;
    end else begin
      dim = 5'd30;
    end

    step7_nxt.pal = (m_tens == yl_ones) && (m_ones == yl_tens) &&
                    (dig_i.day_tens == yh_ones) && (d_ones == dig_i.yh_tens);
    step7_nxt.ovf  = 1'b0;
    step7_nxt.date = date_i;
    year_end = 1'b0;
    if ((date_i.day >= 7'd1) && (date_i.day < {2'd0, dim})) begin
      step7_nxt.date.day = 7'(date_i.day + 7'd1);
    end else if ((date_i.month >= 4'd1) && (date_i.month < 4'(MONTH_MAX))) begin
      step7_nxt.date.day   = 7'd1;
      step7_nxt.date.month = 4'(date_i.month + 4'd1);
    end else begin
      year_end = 1'b1;
      step7_nxt.date.day   = 7'd1;
      step7_nxt.date.month = 4'd1;
      if (date_i.year == 14'd9999) begin
        step7_nxt.date.year = '0;
        step7_nxt.ovf       = 1'b1;
      end else begin
        step7_nxt.date.year = 14'(date_i.year + 14'd1);
      end
    end
  end

  assign next8_nxt = {20'd0, step7_r.date.month} * MONTH_UNIT +
                     {17'd0, step7_r.date.day} * DAY_UNIT +
                     {10'd0, step7_r.date.year};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow7_r  <= '0;
      valid8_r <= 1'b0;
    end else if (adv) begin
      flow7_r  <= flow_i;
      valid8_r <= flow7_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step7_r <= step7_nxt;
      next8_r <= flow7_r.err ? '0 : next8_nxt;
      pal8_r  <= step7_r.pal && !flow7_r.err;
      ovf8_r  <= step7_r.ovf && !flow7_r.err;
      err8_r  <= flow7_r.err;
    end
  end

  assign out_valid = valid8_r;
  assign next_date = next8_r;
  assign is_pal    = pal8_r;
  assign range_err = err8_r;
  assign year_ovf  = ovf8_r;

  `ASSERT_IMPLY(a_wrap_only_dec, clk, rst_n, flow_i.valid && !flow_i.err && year_end, date_i.month == 4'd12 || date_i.month == 4'd0)

endmodule
